// ===== src/ltwe_pkg.sv =====
// Shared types, constants and register codes for the LED twinkle envelope core.
package ltwe_pkg;

   // Field widths
   localparam int PIXEL_W   = 8;
   localparam int BRIGHT_W  = 16;
   localparam int LEVEL_W   = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // Pixel index widened far enough to compare against any supported pixel count
   localparam int IDX_EXT_W = 13;

   // One quotient bit is resolved per divider stage
   localparam int DIV_STEPS = LEVEL_W;

   // Default pixel count
   localparam int PIXEL_COUNT_DEF = 256;

   // Register reset values
   localparam logic [BRIGHT_W-1:0] MIN_LEVEL_RST  = 16'd0;
   localparam logic [BRIGHT_W-1:0] MAX_LEVEL_RST  = 16'd65280;
   localparam logic [BRIGHT_W-1:0] STEP_SIZE_RST  = 16'd256;
   localparam logic [BRIGHT_W-1:0] OUT_DIV_RST    = 16'd256;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_LEVEL      = 2'd0,
      CSR_MAX_LEVEL      = 2'd1,
      CSR_STEP_SIZE      = 2'd2,
      CSR_OUTPUT_DIVISOR = 2'd3
   } csr_index_type;

   // Per-pixel state word kept in the state memory
   typedef struct packed {
      logic                active;
      logic                rising;
      logic [BRIGHT_W-1:0] bright;
   } pixel_state_type;

   localparam pixel_state_type PIXEL_STATE_RST = '{active: 1'b0, rising: 1'b1, bright: '0};

   // Beat handed from the update stage to the divider
   typedef struct packed {
      logic [PIXEL_W-1:0]  pixel;
      logic                active;
      logic [BRIGHT_W-1:0] bright;
   } div_in_type;

   // One divider pipeline stage
   typedef struct packed {
      logic [PIXEL_W-1:0]  pixel;
      logic                active;
      logic [BRIGHT_W-1:0] rem;
      logic [LEVEL_W-1:0]  quo;
      logic                sat;
   } div_stage_type;

endpackage

// ===== src/ltwe_state_mem.sv =====
// Per-pixel state memory: one write port, one registered read port.
module ltwe_state_mem #(
   parameter int DEPTH  = ltwe_pkg::PIXEL_COUNT_DEF,
   parameter int ADDR_W = 8
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  ltwe_pkg::pixel_state_type wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output ltwe_pkg::pixel_state_type rd_data
);
   import ltwe_pkg::*;

   pixel_state_type mem [DEPTH];
   pixel_state_type rd_data_ff;

   // Write the entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, hold while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ltwe_divider.sv =====
// Pipelined restoring divider: brightness over divisor, saturated to 8 bits.
module ltwe_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  ltwe_pkg::div_in_type            in_data,
   input  logic [ltwe_pkg::BRIGHT_W-1:0]   divisor,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [ltwe_pkg::PIXEL_W-1:0]    out_pixel,
   output logic [ltwe_pkg::LEVEL_W-1:0]    out_level,
   output logic                            out_active
);
   import ltwe_pkg::*;

   localparam int SHIFT_W = BRIGHT_W + DIV_STEPS;

   div_stage_type        st_ff [DIV_STEPS+1];
   div_stage_type        st_in [DIV_STEPS+1];
   logic [DIV_STEPS:0]   v_ff;
   logic [DIV_STEPS+1:0] rdy;

   // Advance each stage when it is empty or its successor advances
   always_comb begin
      rdy[DIV_STEPS+1] = out_ready;
      for (int k = DIV_STEPS; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   // Resolve one quotient bit per stage, check saturation in the first
   always_comb begin
      logic [SHIFT_W-1:0] shifted;
      logic               ge;
      shifted = '0;
      ge      = 1'b0;
      st_in[0].pixel  = in_data.pixel;
      st_in[0].active = in_data.active;
      st_in[0].rem    = in_data.bright;
      st_in[0].quo    = '0;
      st_in[0].sat    = 1'b0;
      for (int k = 1; k <= DIV_STEPS; k++) begin
         st_in[k] = st_ff[k-1];
         shifted  = SHIFT_W'(divisor) << (DIV_STEPS - k);
         ge       = SHIFT_W'(st_ff[k-1].rem) >= shifted;
         if (ge) begin
            st_in[k].rem                 = st_ff[k-1].rem - shifted[BRIGHT_W-1:0];
            st_in[k].quo[DIV_STEPS - k]  = 1'b1;
         end
         if (k == 1) begin
            st_in[k].sat = (st_ff[k-1].rem >> DIV_STEPS) >= divisor;
         end
      end
   end

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k <= DIV_STEPS; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      for (int k = 0; k <= DIV_STEPS; k++) begin
         if (rdy[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign in_ready   = rdy[0];
   assign out_valid  = v_ff[DIV_STEPS];
   assign out_pixel  = st_ff[DIV_STEPS].pixel;
   assign out_active = st_ff[DIV_STEPS].active;
   assign out_level  = st_ff[DIV_STEPS].sat ? {LEVEL_W{1'b1}} : st_ff[DIV_STEPS].quo;

   // An idle pixel always renders dark
   a_idle_dark: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_active |-> out_level == '0)
      else $error("idle pixel rendered with nonzero level");

   // A stalled result beat holds its level
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_level))
      else $error("stalled result level changed");

   // Saturation implies the brightness reached 256 times the divisor
   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[DIV_STEPS] && st_ff[DIV_STEPS].sat |-> divisor <= BRIGHT_W'(255))
      else $error("saturation with a divisor too large to saturate");

endmodule

// ===== src/led_twinkle_envelope_core.sv =====
// Top level of the LED twinkle envelope core: registers, state update and result path.
//
//   channel   ports                                        direction
//   req       req_valid/req_ready, pixel_index, start      in, one pixel update per beat
//   rsp       rsp_valid/rsp_ready, out_pixel/level/active  out, one result per update
//   csr       csr_wr_en, csr_index, csr_wr_data            in, register write, no wait
//
// Throughput is one update per cycle while rsp_ready is high and no clearing pass runs; an update
// passes through one memory read/update stage, one divider entry stage and eight divider bit
// stages before rsp_valid rises for its result.
// Updates to the same pixel in consecutive cycles are forwarded around the state memory.
// After reset a clearing pass writes every state entry, with req_ready low.
// A stalled rsp channel backs up stage by stage; bubbles in the pipeline are filled first.
module led_twinkle_envelope_core #(
   parameter int PIXEL_COUNT = ltwe_pkg::PIXEL_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ltwe_pkg::PIXEL_W-1:0]    req_pixel_index,
   input  logic                            req_start_request,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ltwe_pkg::PIXEL_W-1:0]    rsp_out_pixel,
   output logic [ltwe_pkg::LEVEL_W-1:0]    rsp_out_level,
   output logic                            rsp_out_active,
   input  logic                            csr_wr_en,
   input  logic [ltwe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ltwe_pkg::CSR_DAT_W-1:0]  csr_wr_data
);
   import ltwe_pkg::*;

   localparam int ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

   // Configuration registers
   logic [BRIGHT_W-1:0] min_level_ff;
   logic [BRIGHT_W-1:0] max_level_ff;
   logic [BRIGHT_W-1:0] step_size_ff;
   logic [BRIGHT_W-1:0] out_div_ff;
   logic [BRIGHT_W-1:0] div_eff;

   // Clearing pass
   logic                clr_busy_ff;
   logic [ADDR_W-1:0]   clr_addr_ff;

   // Update stage
   logic                s1_v_ff;
   logic [PIXEL_W-1:0]  s1_idx_ff;
   logic                s1_start_ff;
   logic                s1_inr_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic                fwd_sel_ff;
   logic                fwd_sel_in;
   pixel_state_type     fwd_ff;
   pixel_state_type     s1_old;
   pixel_state_type     s1_new;

   // Input decode
   logic [IDX_EXT_W-1:0] req_idx_ext;
   logic [ADDR_W-1:0]    req_addr;
   logic                 req_inr;
   logic                 accept;
   logic                 s1_adv;

   // Memory ports
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   pixel_state_type      wr_data;
   pixel_state_type      mem_rd;

   // Divider link
   logic                 div_in_ready;
   div_in_type           div_in;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_level_ff <= MIN_LEVEL_RST;
         max_level_ff <= MAX_LEVEL_RST;
         step_size_ff <= STEP_SIZE_RST;
         out_div_ff   <= OUT_DIV_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MIN_LEVEL:      min_level_ff <= csr_wr_data;
            CSR_MAX_LEVEL:      max_level_ff <= csr_wr_data;
            CSR_STEP_SIZE:      step_size_ff <= csr_wr_data;
            CSR_OUTPUT_DIVISOR: out_div_ff   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Treat a zero divisor as one
   assign div_eff = (out_div_ff == '0) ? BRIGHT_W'(1) : out_div_ff;

   // Sweep the state memory after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == ADDR_W'(PIXEL_COUNT - 1)) begin
            clr_busy_ff <= 1'b0;
         end else begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         end
      end
   end

   // Decode the incoming pixel index
   assign req_idx_ext = IDX_EXT_W'(req_pixel_index);
   assign req_addr    = req_idx_ext[ADDR_W-1:0];
   assign req_inr     = req_idx_ext < IDX_EXT_W'(PIXEL_COUNT);

   // Handshake of the update stage
   assign s1_adv    = s1_v_ff && div_in_ready;
   assign req_ready = !clr_busy_ff && (!s1_v_ff || div_in_ready);
   assign accept    = req_valid && req_ready;

   // Forward a write-back that lands on the entry being read
   assign fwd_sel_in = s1_adv && s1_inr_ff && req_inr && (s1_addr_ff == req_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff    <= 1'b0;
         fwd_sel_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_v_ff    <= 1'b1;
            fwd_sel_ff <= fwd_sel_in;
         end else if (s1_adv) begin
            s1_v_ff    <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff   <= req_pixel_index;
         s1_start_ff <= req_start_request;
         s1_inr_ff   <= req_inr;
         s1_addr_ff  <= req_addr;
         fwd_ff      <= s1_new;
      end
   end

   assign s1_old = fwd_sel_ff ? fwd_ff : mem_rd;

   // Start, step up with clamp, or step down toward idle
   always_comb begin
      logic [BRIGHT_W:0] sum;
      s1_new = s1_old;
      sum    = '0;
      if (!s1_new.active && s1_start_ff) begin
         s1_new.active = 1'b1;
         s1_new.rising = 1'b1;
         s1_new.bright = min_level_ff;
      end
      if (s1_new.active) begin
         if (s1_new.rising) begin
            sum = {1'b0, s1_new.bright} + {1'b0, step_size_ff};
            if (sum >= {1'b0, max_level_ff}) begin
               s1_new.bright = max_level_ff;
               s1_new.rising = 1'b0;
            end else begin
               s1_new.bright = sum[BRIGHT_W-1:0];
            end
         end else begin
            if (s1_new.bright < step_size_ff) begin
               s1_new.bright = '0;
            end else begin
               s1_new.bright = s1_new.bright - step_size_ff;
            end
            if (s1_new.bright == '0) begin
               s1_new.rising = 1'b1;
               s1_new.active = 1'b0;
            end
         end
      end
   end

   // Memory write port: clearing pass or write-back
   assign wr_en   = clr_busy_ff || (s1_adv && s1_inr_ff);
   assign wr_addr = clr_busy_ff ? clr_addr_ff : s1_addr_ff;
   assign wr_data = clr_busy_ff ? PIXEL_STATE_RST : s1_new;

   ltwe_state_mem #(
      .DEPTH  (PIXEL_COUNT),
      .ADDR_W (ADDR_W)
   ) u_state_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (mem_rd)
   );

   // Drop state for out-of-range pixels
   assign div_in.pixel  = s1_idx_ff;
   assign div_in.active = s1_inr_ff && s1_new.active;
   assign div_in.bright = s1_inr_ff ? s1_new.bright : '0;

   ltwe_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_v_ff),
      .in_ready   (div_in_ready),
      .in_data    (div_in),
      .divisor    (div_eff),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_pixel  (rsp_out_pixel),
      .out_level  (rsp_out_level),
      .out_active (rsp_out_active)
   );

   // No update in flight while the clearing pass owns the write port
   a_clr_exclusive: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !s1_v_ff && !req_ready)
      else $error("update in flight during clearing pass");

   // An idle pixel is stored with zero brightness
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && s1_inr_ff && !s1_new.active |-> s1_new.bright == '0)
      else $error("idle pixel left with nonzero brightness");

   // A stalled update beat keeps its pixel and its read data
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && !div_in_ready |=> s1_v_ff && $stable(s1_idx_ff) && $stable(s1_old))
      else $error("stalled update beat changed");

endmodule
